@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: %m");

// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition: %m");

`endif

@@ sv/bvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bvm_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANG_W = 32;
	localparam int RW = 34;   // rotation datapath, Q2.30 plus headroom
	localparam int VW = 36;   // vectoring datapath
	localparam int CFG_IDX_W = 8;
	localparam logic signed [RW-1:0] K_INV = 34'sd652032874;
	localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam int VMG_LIMIT = 65535;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARK_LAT = 8'd0,
		REG_MARK_LON = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                 flip;
		logic signed [RW-1:0] z;
	} rot_prep_t;

	function automatic logic [ANG_W-1:0] arc_angle(input int unsigned i);
		logic [ANG_W-1:0] a;
		unique case (i)
			0: a = 32'd536870912;  1: a = 32'd316933406;  2: a = 32'd167458907;
			3: a = 32'd85004756;   4: a = 32'd42667331;   5: a = 32'd21354465;
			6: a = 32'd10680862;   7: a = 32'd5340245;    8: a = 32'd2670163;
			9: a = 32'd1335087;    10: a = 32'd667544;    11: a = 32'd333772;
			12: a = 32'd166886;    13: a = 32'd83443;     14: a = 32'd41722;
			15: a = 32'd20861;     16: a = 32'd10430;     17: a = 32'd5215;
			18: a = 32'd2608;      19: a = 32'd1304;      20: a = 32'd652;
			21: a = 32'd326;       22: a = 32'd163;       23: a = 32'd81;
			24: a = 32'd41;        25: a = 32'd20;        26: a = 32'd10;
			27: a = 32'd5;         28: a = 32'd3;         29: a = 32'd1;
			30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	// fold angles beyond +-90 deg by a half turn, flag to negate the result
	function automatic rot_prep_t rot_prep(input logic [ANG_W-1:0] ang);
		rot_prep_t r;
		logic [ANG_W-1:0] t;
		logic [ANG_W-1:0] a;
		t = ang + QUARTER_TURN;
		r.flip = t[ANG_W-1];
		a = r.flip ? (ang - HALF_TURN) : ang;
		r.z = {{(RW-ANG_W){a[ANG_W-1]}}, a};
		return r;
	endfunction

	// Q2.30 product, floored to Q6.30 (VW bits)
	function automatic logic signed [VW-1:0] mulq(input logic signed [RW-1:0] a,
		input logic signed [RW-1:0] b);
		logic signed [2*RW-1:0] p;
		p = a * b;
		return p[30 +: VW];
	endfunction

endpackage
`default_nettype wire

@@ sv/bvm_rot_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bvm_rot_cell #(
	parameter int STAGE = 0,
	parameter int NL = 1,
	parameter int PW = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [NL-1:0][bvm_pkg::RW-1:0]      in_x,
	input  logic [NL-1:0][bvm_pkg::RW-1:0]      in_y,
	input  logic [NL-1:0][bvm_pkg::RW-1:0]      in_z,
	input  logic [NL-1:0]                       in_flip,
	input  logic [PW-1:0]                       in_pass,
	output logic                                out_vld,
	output logic [NL-1:0][bvm_pkg::RW-1:0]      out_x,
	output logic [NL-1:0][bvm_pkg::RW-1:0]      out_y,
	output logic [NL-1:0][bvm_pkg::RW-1:0]      out_z,
	output logic [NL-1:0]                       out_flip,
	output logic [PW-1:0]                       out_pass
);
	import bvm_pkg::*;

	localparam logic signed [RW-1:0] ARC = {{(RW-ANG_W){1'b0}}, arc_angle(STAGE)};

	logic [NL-1:0][RW-1:0] x_d, y_d, z_d;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (!in_z[l][RW-1]) begin
				x_d[l] = $signed(in_x[l]) - ($signed(in_y[l]) >>> STAGE);
				y_d[l] = $signed(in_y[l]) + ($signed(in_x[l]) >>> STAGE);
				z_d[l] = $signed(in_z[l]) - ARC;
			end else begin
				x_d[l] = $signed(in_x[l]) + ($signed(in_y[l]) >>> STAGE);
				y_d[l] = $signed(in_y[l]) - ($signed(in_x[l]) >>> STAGE);
				z_d[l] = $signed(in_z[l]) + ARC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_x    <= x_d;
		out_y    <= y_d;
		out_z    <= z_d;
		out_flip <= in_flip;
		out_pass <= in_pass;
	end

endmodule
`default_nettype wire

@@ sv/bvm_vec_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bvm_vec_cell #(
	parameter int STAGE = 0,
	parameter int PW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [bvm_pkg::VW-1:0]     in_east,
	input  logic [bvm_pkg::VW-1:0]     in_north,
	input  logic [bvm_pkg::ANG_W-1:0]  in_z,
	input  logic [PW-1:0]              in_pass,
	output logic                       out_vld,
	output logic [bvm_pkg::VW-1:0]     out_east,
	output logic [bvm_pkg::VW-1:0]     out_north,
	output logic [bvm_pkg::ANG_W-1:0]  out_z,
	output logic [PW-1:0]              out_pass
);
	import bvm_pkg::*;

	localparam logic [ANG_W-1:0] ARC = arc_angle(STAGE);

	logic [VW-1:0]    east_d, north_d;
	logic [ANG_W-1:0] z_d;

	always_comb begin
		if (!in_east[VW-1]) begin
			north_d = $signed(in_north) + ($signed(in_east) >>> STAGE);
			east_d  = $signed(in_east) - ($signed(in_north) >>> STAGE);
			z_d     = in_z + ARC;
		end else begin
			north_d = $signed(in_north) - ($signed(in_east) >>> STAGE);
			east_d  = $signed(in_east) + ($signed(in_north) >>> STAGE);
			z_d     = in_z - ARC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_east  <= east_d;
		out_north <= north_d;
		out_z     <= z_d;
		out_pass  <= in_pass;
	end

endmodule
`default_nettype wire

@@ sv/bearing_and_vmg_to_mark.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a fix accepted at a clock edge passes three CORDIC cell chains plus eleven glue
// registers, the first of which loads at the accepting edge itself; done rises as the last
// one loads, and the result transfers at the edge after.
// Throughput: one fix per clock; busy stays low, the pipeline never stalls.
// The receiver cannot stall: each result shows for exactly one cycle with done.
// Reset (arst_n low, asynchronous) clears all valid bits and both mark registers.
`include "assert_macros.svh"
module bearing_and_vmg_to_mark #(
	parameter int CORDIC_STAGES = bvm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// fix input
	input  logic                           start,
	output logic                           busy,
	input  logic signed [31:0]             own_latitude,
	input  logic signed [31:0]             own_longitude,
	input  logic [15:0]                    ground_speed,
	input  logic [15:0]                    ground_course,
	// results
	output logic                           done,
	output logic [15:0]                    bearing_to_mark,
	output logic signed [16:0]             made_good_velocity,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import bvm_pkg::*;

	localparam int S = CORDIC_STAGES;

	// ---------------------------------------------------------------- config
	logic [ANG_W-1:0] mark_lat_q, mark_lon_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_lat_q <= '0;
			mark_lon_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MARK_LAT) begin
				mark_lat_q <= cfg_data;
			end else if (cfg_index == REG_MARK_LON) begin
				mark_lon_q <= cfg_data;
			end
		end
	end

	// ---------------------------------------------------------------- s1: fold angles
	// lanes: 0 own latitude, 1 mark latitude, 2 longitude difference
	logic              vld_s1;
	rot_prep_t [2:0]   rp_s1;
	logic [31:0]       pay_s1;
	rot_prep_t [2:0]   rp_d;

	always_comb begin
		rp_d[0] = rot_prep(own_latitude);
		rp_d[1] = rot_prep(mark_lat_q);
		rp_d[2] = rot_prep(mark_lon_q - own_longitude);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		rp_s1  <= rp_d;
		pay_s1 <= {ground_speed, ground_course};
	end

	// ---------------------------------------------------------------- chain 1: sin/cos x3
	logic [S:0]                  ca_vld;
	logic [S:0][2:0][RW-1:0]     ca_x, ca_y, ca_z;
	logic [S:0][2:0]             ca_flip;
	logic [S:0][31:0]            ca_pass;

	assign ca_vld[0]  = vld_s1;
	assign ca_pass[0] = pay_s1;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			ca_x[0][l]    = K_INV;
			ca_y[0][l]    = '0;
			ca_z[0][l]    = rp_s1[l].z;
			ca_flip[0][l] = rp_s1[l].flip;
		end
	end

	for (genvar g = 0; g < S; g++) begin : g_ca
		bvm_rot_cell #(.STAGE(g), .NL(3), .PW(32)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_vld(ca_vld[g]), .in_x(ca_x[g]), .in_y(ca_y[g]), .in_z(ca_z[g]),
			.in_flip(ca_flip[g]), .in_pass(ca_pass[g]),
			.out_vld(ca_vld[g+1]), .out_x(ca_x[g+1]), .out_y(ca_y[g+1]),
			.out_z(ca_z[g+1]), .out_flip(ca_flip[g+1]), .out_pass(ca_pass[g+1])
		);
	end

	// ---------------------------------------------------------------- s2: undo fold
	logic                      vld_s2;
	logic [2:0][RW-1:0]        sin_s2, cos_s2;
	logic [31:0]               pay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ca_vld[S];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			sin_s2[l] <= ca_flip[S][l] ? -$signed(ca_y[S][l]) : ca_y[S][l];
			cos_s2[l] <= ca_flip[S][l] ? -$signed(ca_x[S][l]) : ca_x[S][l];
		end
		pay_s2 <= ca_pass[S];
	end

	// ---------------------------------------------------------------- s3..s5: products
	logic             vld_s3, vld_s4, vld_s5;
	logic [VW-1:0]    east_s3, n1_s3, sc_s3;
	logic [RW-1:0]    cd_s3;
	logic [VW-1:0]    east_s4, n1_s4, q_s4;
	logic [VW-1:0]    east_s5, north_s5;
	logic [31:0]      pay_s3, pay_s4, pay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// east = sin(dLon)cos(lat2); north = cos(lat1)sin(lat2) - sin(lat1)cos(lat2)cos(dLon)
		east_s3 <= mulq(sin_s2[2], cos_s2[1]);
		n1_s3   <= mulq(cos_s2[0], sin_s2[1]);
		sc_s3   <= mulq(sin_s2[0], cos_s2[1]);
		cd_s3   <= cos_s2[2];
		pay_s3  <= pay_s2;

		east_s4 <= east_s3;
		n1_s4   <= n1_s3;
		q_s4    <= mulq(sc_s3[RW-1:0], cd_s3);
		pay_s4  <= pay_s3;

		east_s5  <= east_s4;
		north_s5 <= $signed(n1_s4) - $signed(q_s4);
		pay_s5   <= pay_s4;
	end

	// ---------------------------------------------------------------- s6: vectoring setup
	logic             vld_s6, zero_s6;
	logic [VW-1:0]    east_s6, north_s6;
	logic [ANG_W-1:0] z_s6;
	logic [31:0]      pay_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		zero_s6 <= (east_s5 == '0) && (north_s5 == '0);
		// southward vector: turn by a half turn so the chain stays in range
		if (north_s5[VW-1]) begin
			east_s6  <= -$signed(east_s5);
			north_s6 <= -$signed(north_s5);
			z_s6     <= HALF_TURN;
		end else begin
			east_s6  <= east_s5;
			north_s6 <= north_s5;
			z_s6     <= '0;
		end
		pay_s6 <= pay_s5;
	end

	// ---------------------------------------------------------------- chain 2: atan2
	logic [S:0]             vc_vld;
	logic [S:0][VW-1:0]     vc_east, vc_north;
	logic [S:0][ANG_W-1:0]  vc_z;
	logic [S:0][32:0]       vc_pass;

	assign vc_vld[0]   = vld_s6;
	assign vc_east[0]  = east_s6;
	assign vc_north[0] = north_s6;
	assign vc_z[0]     = z_s6;
	assign vc_pass[0]  = {zero_s6, pay_s6};

	for (genvar g = 0; g < S; g++) begin : g_vc
		bvm_vec_cell #(.STAGE(g), .PW(33)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_vld(vc_vld[g]), .in_east(vc_east[g]), .in_north(vc_north[g]),
			.in_z(vc_z[g]), .in_pass(vc_pass[g]),
			.out_vld(vc_vld[g+1]), .out_east(vc_east[g+1]), .out_north(vc_north[g+1]),
			.out_z(vc_z[g+1]), .out_pass(vc_pass[g+1])
		);
	end

	// ---------------------------------------------------------------- s7: round bearing
	logic             vld_s7;
	logic [15:0]      brg_s7;
	logic [31:0]      pay_s7;
	logic [ANG_W-1:0] full_d;
	logic [ANG_W-1:0] rnd_d;

	always_comb begin
		// a zero east/north vector, as from coincident points, gives north
		full_d = vc_pass[S][32] ? '0 : vc_z[S];
		rnd_d  = full_d + 32'h0000_8000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vc_vld[S];
		end
	end

	always_ff @(posedge clk) begin
		brg_s7 <= rnd_d[31:16];
		pay_s7 <= vc_pass[S][31:0];
	end

	// ---------------------------------------------------------------- s8: relative course
	logic        vld_s8;
	rot_prep_t   rp_s8;
	logic [15:0] brg_s8, spd_s8;
	logic [15:0] diff_d;

	assign diff_d = pay_s7[15:0] - brg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		rp_s8  <= rot_prep({diff_d, 16'h0000});
		brg_s8 <= brg_s7;
		spd_s8 <= pay_s7[31:16];
	end

	// ---------------------------------------------------------------- chain 3: cos(course - bearing)
	logic [S:0]               cb_vld;
	logic [S:0][0:0][RW-1:0]  cb_x, cb_y, cb_z;
	logic [S:0][0:0]          cb_flip;
	logic [S:0][31:0]         cb_pass;

	assign cb_vld[0]     = vld_s8;
	assign cb_x[0][0]    = K_INV;
	assign cb_y[0][0]    = '0;
	assign cb_z[0][0]    = rp_s8.z;
	assign cb_flip[0][0] = rp_s8.flip;
	assign cb_pass[0]    = {spd_s8, brg_s8};

	for (genvar g = 0; g < S; g++) begin : g_cb
		bvm_rot_cell #(.STAGE(g), .NL(1), .PW(32)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_vld(cb_vld[g]), .in_x(cb_x[g]), .in_y(cb_y[g]), .in_z(cb_z[g]),
			.in_flip(cb_flip[g]), .in_pass(cb_pass[g]),
			.out_vld(cb_vld[g+1]), .out_x(cb_x[g+1]), .out_y(cb_y[g+1]),
			.out_z(cb_z[g+1]), .out_flip(cb_flip[g+1]), .out_pass(cb_pass[g+1])
		);
	end

	// ---------------------------------------------------------------- s9..s11: VMG
	logic                    vld_s9, vld_s10;
	logic signed [RW-1:0]    cv_s9;
	logic [31:0]             pay_s9;
	logic signed [20:0]      vmg_s10;
	logic [15:0]             brg_s10;
	logic signed [50:0]      prod_d;
	logic signed [50:0]      acc_d;

	always_comb begin
		prod_d = $signed({1'b0, pay_s9[31:16]}) * cv_s9;
		acc_d  = prod_d + 51'sd536870912;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s9  <= cb_vld[S];
			vld_s10 <= vld_s9;
			done    <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		cv_s9   <= cb_flip[S][0] ? -$signed(cb_x[S][0]) : $signed(cb_x[S][0]);
		pay_s9  <= cb_pass[S];
		vmg_s10 <= acc_d[50:30];
		brg_s10 <= pay_s9[15:0];
		bearing_to_mark <= brg_s10;
		if (vmg_s10 > 21'sd65535) begin
			made_good_velocity <= 17'sd65535;
		end else if (vmg_s10 < -21'sd65535) begin
			made_good_velocity <= -17'sd65535;
		end else begin
			made_good_velocity <= vmg_s10[16:0];
		end
	end

	// ---------------------------------------------------------------- checks
	`ASSERT_CLK(a_zero_vec_north, clk, arst_n, (vc_vld[S] && vc_pass[S][32]) |=> (brg_s7 == '0))
	`ASSERT_NEVER(a_vec_start_north, clk, arst_n, vld_s6 && north_s6[VW-1] && !zero_s6)
	`ASSERT_NEVER(a_vmg_sat, clk, arst_n, done && (made_good_velocity == -17'sd65536))

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Checks bearing_and_vmg_to_mark against its own bit-exact model of the
// CORDIC arithmetic. Fixes stream in bursts with gaps, the mark moves between
// phases, and every done strobe is matched against the oldest prediction.
module testbench;
	import bvm_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	// the fix-to-result pipeline depth; the drain wait covers it
	localparam int PIPE_LATENCY = 3 * STAGES + 11;
	localparam int CYCLE_LIMIT = 400000;
	// a register index that the block has to ignore
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 8'd7;
	localparam int FIXES_PER_PHASE = 200;

	typedef struct packed {
		logic [31:0] lat;
		logic [31:0] lon;
		logic [15:0] speed;
		logic [15:0] course;
	} fix_t;

	typedef struct packed {
		logic [15:0] bearing;
		logic [16:0] vmg;
	} nav_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	fix_t drv_fix = '0;
	logic done;
	logic [15:0] bearing_to_mark;
	logic signed [16:0] made_good_velocity;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	fix_t pending_fixes[$];
	nav_result_t expected_nav[$];
	bit [31:0] mark_lat_m = 0;
	bit [31:0] mark_lon_m = 0;
	bit hold_fixes = 0;
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;

	bearing_and_vmg_to_mark u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.own_latitude(drv_fix.lat), .own_longitude(drv_fix.lon),
		.ground_speed(drv_fix.speed), .ground_course(drv_fix.course),
		.done(done), .bearing_to_mark(bearing_to_mark),
		.made_good_velocity(made_good_velocity),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// arctangent steps, 2^32 per turn
	function automatic longint arc_step(input int i);
		longint steps[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return steps[i];
	endfunction

	// rotation CORDIC, Q2.30; angles past +-90 deg folded and negated
	function automatic void rotate_unit(input bit [31:0] ang, output longint sn,
		output longint cs);
		bit flip;
		bit [31:0] a;
		bit [31:0] t;
		longint x, y, z, dx, dy;
		t = ang + 32'h4000_0000;
		flip = t[31];
		a = flip ? ang - 32'h8000_0000 : ang;
		z = longint'($signed(a));
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	// vectoring CORDIC: clockwise angle of (east, north) from north
	function automatic bit [31:0] heading_angle(input longint east, input longint north);
		bit [31:0] z;
		longint dn, de;
		z = 0;
		if (east == 0 && north == 0)
			return 0;
		if (north < 0) begin
			north = -north;
			east = -east;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			dn = east >>> i;
			de = north >>> i;
			if (east >= 0) begin
				north += dn; east -= de; z += 32'(arc_step(i));
			end else begin
				north -= dn; east += de; z -= 32'(arc_step(i));
			end
		end
		return z;
	endfunction

	function automatic nav_result_t predict_nav(input fix_t f);
		nav_result_t r;
		longint s1, c1, s2, c2, sd, cd, sv, cv, east, north, vmg;
		bit [31:0] full;
		bit [32:0] rounded;
		bit [15:0] brg, diff;
		rotate_unit(f.lat, s1, c1);
		rotate_unit(mark_lat_m, s2, c2);
		rotate_unit(mark_lon_m - f.lon, sd, cd);
		east = q30_mul(sd, c2);
		north = q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cd);
		full = heading_angle(east, north);
		rounded = {1'b0, full} + 33'h8000;
		brg = rounded[31:16];
		diff = f.course - brg;
		rotate_unit({diff, 16'h0}, sv, cv);
		vmg = (longint'(f.speed) * cv + 64'sd536870912) >>> 30;
		if (vmg > VMG_LIMIT)
			vmg = VMG_LIMIT;
		if (vmg < -VMG_LIMIT)
			vmg = -VMG_LIMIT;
		r.bearing = brg;
		r.vmg = vmg[16:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Driver: a transfer happens at an edge with start high and busy low. The
	// next fix is chosen at that same edge, so start stays high through a burst.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
		end else begin
			if (start && !busy)
				expected_nav.push_back(predict_nav(drv_fix));
			if (start && busy) begin
				// hold the fix until it is taken
			end else if (gap_left > 0) begin
				start <= 0;
				gap_left <= gap_left - 1;
			end else if (!hold_fixes && pending_fixes.size() > 0) begin
				drv_fix <= pending_fixes.pop_front();
				start <= 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// a third of the bursts run back to back
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 0;
			end
		end
	end

	// Monitor: results cannot be held off, so take each one on its strobe edge.
	always @(posedge clk) begin
		nav_result_t want;
		if (arst_n && done) begin
			if (expected_nav.size() == 0) begin
				report_mismatch("unexpected result count", 1, 0);
			end else begin
				want = expected_nav.pop_front();
				if (bearing_to_mark !== want.bearing)
					report_mismatch("bearing", bearing_to_mark, want.bearing);
				if (made_good_velocity !== $signed(want.vmg))
					report_mismatch("vmg", made_good_velocity, $signed(want.vmg));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 0;
		if (idx == REG_MARK_LAT)
			mark_lat_m = value;
		else if (idx == REG_MARK_LON)
			mark_lon_m = value;
	endtask

	task automatic wait_idle();
		wait (pending_fixes.size() == 0 && expected_nav.size() == 0 && !start);
		repeat (PIPE_LATENCY + 5) @(posedge clk);
	endtask

	function automatic fix_t random_fix();
		fix_t f;
		// mostly legal latitudes, some arbitrary patterns
		if ($urandom_range(0, 4) == 0)
			f.lat = $urandom;
		else
			f.lat = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
		f.lon = $urandom;
		f.speed = $urandom_range(0, 65535);
		f.course = $urandom_range(0, 65535);
		return f;
	endfunction

	function automatic fix_t make_fix(input logic [31:0] lat, input logic [31:0] lon,
		input logic [15:0] speed, input logic [15:0] course);
		fix_t f;
		f.lat = lat; f.lon = lon; f.speed = speed; f.course = course;
		return f;
	endfunction

	initial begin
		logic [31:0] lat_set[8];
		logic [31:0] lon_set[8];
		lat_set = '{32'h4000_0000, 32'hC000_0000, 32'h0, 32'h1234_5678,
			32'hF000_0000, 32'h2AAA_AAAA, 32'h8000_0000, 32'h0};
		lon_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hDEAD_BEEF,
			32'h0000_0001, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0};
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed fixes against the reset mark at (0, 0)
		pending_fixes.push_back(make_fix(0, 0, 16'hFFFF, 0));            // on the mark
		pending_fixes.push_back(make_fix(32'h4000_0000, 0, 16'hFFFF, 16'h8000)); // north pole
		pending_fixes.push_back(make_fix(32'hC000_0000, 0, 16'h0100, 0));        // south pole
		pending_fixes.push_back(make_fix(0, 32'h8000_0000, 16'hFFFF, 16'hFFFF)); // antipode
		pending_fixes.push_back(make_fix(0, 32'h7FFF_FFFF, 16'hFFFF, 16'h4000));
		pending_fixes.push_back(make_fix(0, 32'h4000_0000, 16'hFFFF, 16'hC000));
		pending_fixes.push_back(make_fix(32'h4000_0000, 32'h8000_0000, 0, 16'hFFFF));
		pending_fixes.push_back(make_fix(32'hC000_0000, 32'h7FFF_FFFF, 1, 16'h0001));
		pending_fixes.push_back(make_fix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		pending_fixes.push_back(make_fix(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h2000));
		pending_fixes.push_back(make_fix(32'h7FFF_FFFF, 32'hC000_0000, 16'h7FFF, 16'h6000));
		pending_fixes.push_back(make_fix(32'h1000_0000, 32'hF000_0000, 16'hFFFF, 16'hE000));
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			write_reg(REG_MARK_LAT, (p == 7) ? $urandom : lat_set[p]);
			write_reg(REG_MARK_LON, (p == 7) ? $urandom : lon_set[p]);
			write_reg(UNUSED_REG, $urandom);
			// a fix right on the mark, then random ones
			pending_fixes.push_back(make_fix(mark_lat_m, mark_lon_m, 16'hFFFF, $urandom));
			for (int n = 0; n < FIXES_PER_PHASE; n++)
				pending_fixes.push_back(random_fix());
			if (p == 3) begin
				// pause the sender mid-phase until the pipeline has emptied
				wait (pending_fixes.size() < FIXES_PER_PHASE / 2);
				hold_fixes = 1;
				wait (expected_nav.size() == 0);
				@(posedge clk);
				hold_fixes = 0;
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
